@@ rtl/gpma_pkg.sv @@
// ----------------------------------------------------------------------------
// gpma_pkg: shared types and constants of the gated pose moving average
// Sizes of the window store, the running sums, register map and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gpma_pkg;

   localparam int WINDOW_MAX  = 16;
   localparam int SAMPLE_BITS = 32;
   localparam int CHANNELS    = 7;

   localparam int FIELD_W    = 32;
   localparam int SAMPLE_W   = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
   localparam int COUNT_BITS = $clog2(WINDOW_MAX + 1);
   localparam int SLOT_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CH_BITS    = $clog2(CHANNELS);
   localparam int ADDR_BITS  = $clog2(CHANNELS * WINDOW_MAX);
   localparam int SUM_BITS   = SAMPLE_W + $clog2(WINDOW_MAX);
   localparam int STEP_BITS  = $clog2(SUM_BITS);

   localparam int WLEN_W     = 5;
   localparam int CONF_W     = 16;
   localparam int USED_W     = 5;
   localparam int PADDR_BITS = 3;
   localparam int PDATA_BITS = 32;

   localparam logic [WLEN_W-1:0] WLEN_RESET     = WLEN_W'(5);
   localparam logic [CONF_W-1:0] CONF_MIN_RESET = CONF_W'(32768);

   localparam logic FUNC_POSE       = 1'b0;
   localparam logic FUNC_CONFIDENCE = 1'b1;

   typedef enum logic [0:0] {
      REG_WINDOW_LENGTH  = 1'b0,
      REG_CONF_THRESHOLD = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [WLEN_W-1:0] window_length;
      logic [CONF_W-1:0] conf_threshold;
      logic              clear_window;
   } cfg_type;

   typedef struct packed {
      logic               take;
      logic               rd;
      logic               acc;
      logic               div_start;
      logic               div_store;
      logic               publish;
      logic [CH_BITS-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic pose_go;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/gpma_csr.sv @@
// ----------------------------------------------------------------------------
// gpma_csr: configuration registers
// APB-style slave holding the window length and the confidence threshold.
// ----------------------------------------------------------------------------
module gpma_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gpma_pkg::PADDR_BITS-1:0]   csr_paddr,
   input  logic [gpma_pkg::PDATA_BITS-1:0]   csr_pwdata,
   output logic [gpma_pkg::PDATA_BITS-1:0]   csr_prdata,
   output logic                              csr_pready,
   output gpma_pkg::cfg_type                 cfg
);

   logic [gpma_pkg::WLEN_W-1:0] wlen_ff;
   logic [gpma_pkg::CONF_W-1:0] cmin_ff;
   logic                        wr;
   gpma_pkg::reg_index_type     idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = gpma_pkg::reg_index_type'(csr_paddr[gpma_pkg::PADDR_BITS-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= gpma_pkg::WLEN_RESET;
         cmin_ff <= gpma_pkg::CONF_MIN_RESET;
      end else if (wr) begin
         unique case (idx)
            gpma_pkg::REG_WINDOW_LENGTH: begin
               wlen_ff <= csr_pwdata[gpma_pkg::WLEN_W-1:0];
            end
            gpma_pkg::REG_CONF_THRESHOLD: begin
               cmin_ff <= csr_pwdata[gpma_pkg::CONF_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         gpma_pkg::REG_WINDOW_LENGTH: begin
            csr_prdata = gpma_pkg::PDATA_BITS'(wlen_ff);
         end
         gpma_pkg::REG_CONF_THRESHOLD: begin
            csr_prdata = gpma_pkg::PDATA_BITS'(cmin_ff);
         end
      endcase
   end

   // a window_length write empties the window in the same cycle
   assign cfg.window_length  = wlen_ff;
   assign cfg.conf_threshold = cmin_ff;
   assign cfg.clear_window   = wr && (idx == gpma_pkg::REG_WINDOW_LENGTH);

endmodule

@@ rtl/gpma_div.sv @@
// ----------------------------------------------------------------------------
// gpma_div: serial signed divider
// Restoring division of a running sum by the sample count, one quotient bit
// per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module gpma_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [gpma_pkg::SUM_BITS-1:0]   dividend,
   input  logic [gpma_pkg::COUNT_BITS-1:0]        divisor,
   output logic                                   done,
   output logic signed [gpma_pkg::FIELD_W-1:0]    quotient
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [gpma_pkg::STEP_BITS-1:0]      cnt_ff;
   logic [gpma_pkg::SUM_BITS-1:0]       mag_ff;
   logic [gpma_pkg::COUNT_BITS-1:0]     rem_ff;
   logic [gpma_pkg::COUNT_BITS-1:0]     div_ff;
   logic                                neg_ff;

   logic [gpma_pkg::COUNT_BITS:0]       trial;
   logic                                fits;
   logic [gpma_pkg::COUNT_BITS-1:0]     rem_in;
   logic signed [gpma_pkg::SUM_BITS:0]  q_signed;

   always_comb begin
      trial  = {rem_ff, mag_ff[gpma_pkg::SUM_BITS-1]};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? gpma_pkg::COUNT_BITS'(trial - {1'b0, div_ff})
                    : gpma_pkg::COUNT_BITS'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + gpma_pkg::STEP_BITS'(1);
            if (cnt_ff == gpma_pkg::STEP_BITS'(gpma_pkg::SUM_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[gpma_pkg::SUM_BITS-1];
         mag_ff <= dividend[gpma_pkg::SUM_BITS-1] ? gpma_pkg::SUM_BITS'(-dividend)
                                                  : gpma_pkg::SUM_BITS'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[gpma_pkg::SUM_BITS-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign q_signed = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
   assign quotient = gpma_pkg::FIELD_W'(q_signed);
   assign done     = done_ff;

endmodule

@@ rtl/gpma_dp.sv @@
// ----------------------------------------------------------------------------
// gpma_dp: datapath
// Gate, window bookkeeping, sample store, running sums, divider, result
// staging and the output register.
// ----------------------------------------------------------------------------
module gpma_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gpma_pkg::cfg_type                      cfg,
   input  gpma_pkg::cmd_type                      cmd,
   output gpma_pkg::status_type                   status,
   input  logic                                   req_func,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_pos_x,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_pos_y,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_pos_z,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_w,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_x,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_y,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_z,
   input  logic [gpma_pkg::CONF_W-1:0]            req_confidence_level,
   input  logic                                   req_detected,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_x,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_y,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_z,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qw,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qx,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qy,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qz,
   output logic [gpma_pkg::USED_W-1:0]            rsp_samples_used
);

   localparam int CH = gpma_pkg::CHANNELS;

   logic                                  gate_ff;
   logic [gpma_pkg::COUNT_BITS-1:0]       fill_ff;
   logic [gpma_pkg::SLOT_BITS-1:0]        oldest_ff;
   logic signed [gpma_pkg::SUM_BITS-1:0]  sum_ff [CH];

   logic                                  full_ff;
   logic [gpma_pkg::SLOT_BITS-1:0]        slot_ff;
   logic [gpma_pkg::SAMPLE_W-1:0]         sample_ff [CH];
   logic [gpma_pkg::SAMPLE_W-1:0]         store_mem [gpma_pkg::CHANNELS * gpma_pkg::WINDOW_MAX];
   logic [gpma_pkg::SAMPLE_W-1:0]         rd_ff;
   logic signed [gpma_pkg::FIELD_W-1:0]   stage_ff [CH];
   logic signed [gpma_pkg::FIELD_W-1:0]   out_ff [CH];
   logic [gpma_pkg::USED_W-1:0]           used_ff;
   logic                                  rsp_valid_ff;

   logic signed [gpma_pkg::FIELD_W-1:0]   fields [CH];
   logic [gpma_pkg::COUNT_BITS-1:0]       eff_len;
   logic                                  is_full;
   logic [gpma_pkg::COUNT_BITS:0]         pos_sum;
   logic [gpma_pkg::COUNT_BITS-1:0]       adv;
   logic [gpma_pkg::SLOT_BITS-1:0]        slot_new;
   logic [gpma_pkg::SLOT_BITS-1:0]        oldest_next;
   logic                                  take_pose;
   logic                                  take_conf;
   logic                                  gate_new;
   logic [gpma_pkg::ADDR_BITS-1:0]        addr;
   logic signed [gpma_pkg::SUM_BITS-1:0]  old_term;
   logic signed [gpma_pkg::SUM_BITS-1:0]  new_term;
   logic                                  div_done;
   logic signed [gpma_pkg::FIELD_W-1:0]   quotient;

   assign fields[0] = req_pos_x;
   assign fields[1] = req_pos_y;
   assign fields[2] = req_pos_z;
   assign fields[3] = req_quat_w;
   assign fields[4] = req_quat_x;
   assign fields[5] = req_quat_y;
   assign fields[6] = req_quat_z;

   // clamp the programmed length into 1..WINDOW_MAX
   always_comb begin
      if (cfg.window_length == '0) begin
         eff_len = gpma_pkg::COUNT_BITS'(1);
      end else if (int'(cfg.window_length) > gpma_pkg::WINDOW_MAX) begin
         eff_len = gpma_pkg::COUNT_BITS'(gpma_pkg::WINDOW_MAX);
      end else begin
         eff_len = gpma_pkg::COUNT_BITS'(cfg.window_length);
      end
   end

   always_comb begin
      is_full = (fill_ff >= eff_len);
      pos_sum = (gpma_pkg::COUNT_BITS + 1)'(oldest_ff)
              + (gpma_pkg::COUNT_BITS + 1)'(fill_ff);
      if (pos_sum >= {1'b0, eff_len}) begin
         pos_sum = pos_sum - {1'b0, eff_len};
      end
      adv         = gpma_pkg::COUNT_BITS'(oldest_ff) + gpma_pkg::COUNT_BITS'(1);
      oldest_next = (adv == eff_len) ? '0 : gpma_pkg::SLOT_BITS'(adv);
      slot_new    = is_full ? oldest_ff : gpma_pkg::SLOT_BITS'(pos_sum);
   end

   assign take_pose = cmd.take && (req_func == gpma_pkg::FUNC_POSE) && gate_ff;
   assign take_conf = cmd.take && (req_func == gpma_pkg::FUNC_CONFIDENCE);
   assign gate_new  = (req_confidence_level > cfg.conf_threshold) && req_detected;

   assign addr = gpma_pkg::ADDR_BITS'(cmd.ch) * gpma_pkg::ADDR_BITS'(gpma_pkg::WINDOW_MAX)
               + gpma_pkg::ADDR_BITS'(slot_ff);

   assign old_term = full_ff ? gpma_pkg::SUM_BITS'($signed(rd_ff)) : '0;
   assign new_term = gpma_pkg::SUM_BITS'($signed(sample_ff[cmd.ch]));

   // gate, window bookkeeping and running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff   <= 1'b0;
         fill_ff   <= '0;
         oldest_ff <= '0;
         for (int c = 0; c < CH; c++) begin
            sum_ff[c] <= '0;
         end
      end else begin
         priority if (cfg.clear_window) begin
            fill_ff   <= '0;
            oldest_ff <= '0;
            for (int c = 0; c < CH; c++) begin
               sum_ff[c] <= '0;
            end
         end else if (take_conf) begin
            gate_ff <= gate_new;
            if (!gate_new) begin
               fill_ff   <= '0;
               oldest_ff <= '0;
               for (int c = 0; c < CH; c++) begin
                  sum_ff[c] <= '0;
               end
            end
         end else if (take_pose) begin
            fill_ff   <= is_full ? eff_len : fill_ff + gpma_pkg::COUNT_BITS'(1);
            oldest_ff <= is_full ? oldest_next : oldest_ff;
         end else if (cmd.acc) begin
            sum_ff[cmd.ch] <= sum_ff[cmd.ch] - old_term + new_term;
         end
      end
   end

   // sample latch, store, staging and output payload
   always_ff @(posedge clock) begin
      if (take_pose) begin
         full_ff <= is_full;
         slot_ff <= slot_new;
         for (int c = 0; c < CH; c++) begin
            sample_ff[c] <= fields[c][gpma_pkg::SAMPLE_W-1:0];
         end
      end
      if (cmd.rd) begin
         rd_ff <= store_mem[addr];
      end
      if (cmd.acc) begin
         store_mem[addr] <= sample_ff[cmd.ch];
      end
      if (cmd.div_store) begin
         stage_ff[cmd.ch] <= quotient;
      end
      if (cmd.publish) begin
         for (int c = 0; c < CH; c++) begin
            out_ff[c] <= stage_ff[c];
         end
         used_ff <= gpma_pkg::USED_W'(fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   gpma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff[cmd.ch]),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.pose_go  = (req_func == gpma_pkg::FUNC_POSE) && gate_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_avg_x        = out_ff[0];
   assign rsp_avg_y        = out_ff[1];
   assign rsp_avg_z        = out_ff[2];
   assign rsp_avg_qw       = out_ff[3];
   assign rsp_avg_qx       = out_ff[4];
   assign rsp_avg_qy       = out_ff[5];
   assign rsp_avg_qz       = out_ff[6];
   assign rsp_samples_used = used_ff;

`ifndef NO_ASSERTIONS
   a_closed_gate_empty: assert property (@(posedge clock) disable iff (reset)
      !gate_ff |-> (fill_ff == '0))
      else $error("window not empty while gate closed");

   a_oldest_while_filling: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < eff_len) |-> (oldest_ff == '0))
      else $error("oldest slot moved before window filled");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= gpma_pkg::COUNT_BITS'(gpma_pkg::WINDOW_MAX))
      else $error("fill count above window maximum");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");
`endif

endmodule

@@ rtl/gpma_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpma_ctrl: sequencer
// Walks each pose through store update, per-channel division and publish.
// ----------------------------------------------------------------------------
module gpma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gpma_pkg::status_type  status,
   output gpma_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PUBLISH
   } state_type;

   localparam logic [gpma_pkg::CH_BITS-1:0] LAST_CH =
      gpma_pkg::CH_BITS'(gpma_pkg::CHANNELS - 1);

   state_type                     state_ff;
   logic [gpma_pkg::CH_BITS-1:0]  ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && status.pose_go) begin
                  state_ff <= ST_READ;
                  ch_ff    <= '0;
               end
            end
            ST_READ: begin
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               if (ch_ff == LAST_CH) begin
                  state_ff <= ST_DIV_START;
                  ch_ff    <= '0;
               end else begin
                  state_ff <= ST_READ;
                  ch_ff    <= ch_ff + gpma_pkg::CH_BITS'(1);
               end
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (status.div_done) begin
                  if (ch_ff == LAST_CH) begin
                     state_ff <= ST_PUBLISH;
                  end else begin
                     state_ff <= ST_DIV_START;
                     ch_ff    <= ch_ff + gpma_pkg::CH_BITS'(1);
                  end
               end
            end
            ST_PUBLISH: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.take      = req_valid && (state_ff == ST_IDLE);
   assign cmd.rd        = (state_ff == ST_READ);
   assign cmd.acc       = (state_ff == ST_ACCUM);
   assign cmd.div_start = (state_ff == ST_DIV_START);
   assign cmd.div_store = (state_ff == ST_DIV_WAIT) && status.div_done;
   assign cmd.publish   = (state_ff == ST_PUBLISH) && status.out_free;
   assign cmd.ch        = ch_ff;

`ifndef NO_ASSERTIONS
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside of wait state");
`endif

endmodule

@@ rtl/gated_pose_moving_average.sv @@
// ----------------------------------------------------------------------------
// gated_pose_moving_average: gated boxcar average of pose samples
// Flow: a pose with the gate open keeps the next word waiting until its
//   averages are published, since the serial divider is shared by the seven
//   channels; confidence words and dropped poses keep the sequencer idle.
// Reset: gate closed, window empty, registers at 5 and 32768; the sample store
//   keeps no reset value, since a stored sample is only used after it was written.
// ----------------------------------------------------------------------------
module gated_pose_moving_average (
   input  logic                                   clock,
   input  logic                                   reset,

   // input words: a pose sample or a confidence update
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_pos_x,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_pos_y,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_pos_z,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_w,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_x,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_y,
   input  logic signed [gpma_pkg::FIELD_W-1:0]    req_quat_z,
   input  logic [gpma_pkg::CONF_W-1:0]            req_confidence_level,
   input  logic                                   req_detected,

   // result words: seven averages and the sample count
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_x,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_y,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_z,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qw,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qx,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qy,
   output logic signed [gpma_pkg::FIELD_W-1:0]    rsp_avg_qz,
   output logic [gpma_pkg::USED_W-1:0]            rsp_samples_used,

   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [gpma_pkg::PADDR_BITS-1:0]        csr_paddr,
   input  logic [gpma_pkg::PDATA_BITS-1:0]        csr_pwdata,
   output logic [gpma_pkg::PDATA_BITS-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   // Flow of one pose with the gate open:
   //  - accept: latch the seven samples, pick the slot to overwrite and
   //    advance fill count / oldest slot
   //  - per channel: read the departing sample, then subtract it (only when
   //    the window was full), add the new one and write it to the store
   //  - per channel: divide the running sum by the fill count, truncating
   //    toward zero, and stage the quotient
   //  - publish: move the staged averages into the output register once it
   //    is free; the next word is accepted while the result waits there
   // A confidence word sets the gate and empties the window when it closes.
   // A pose arriving with the gate closed is dropped without a result.

   gpma_pkg::cfg_type     cfg;
   gpma_pkg::cmd_type     cmd;
   gpma_pkg::status_type  status;

   gpma_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gpma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gpma_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .status               (status),
      .req_func             (req_func),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pos_z            (req_pos_z),
      .req_quat_w           (req_quat_w),
      .req_quat_x           (req_quat_x),
      .req_quat_y           (req_quat_y),
      .req_quat_z           (req_quat_z),
      .req_confidence_level (req_confidence_level),
      .req_detected         (req_detected),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_avg_x            (rsp_avg_x),
      .rsp_avg_y            (rsp_avg_y),
      .rsp_avg_z            (rsp_avg_z),
      .rsp_avg_qw           (rsp_avg_qw),
      .rsp_avg_qx           (rsp_avg_qx),
      .rsp_avg_qy           (rsp_avg_qy),
      .rsp_avg_qz           (rsp_avg_qz),
      .rsp_samples_used     (rsp_samples_used)
   );

endmodule

@@ sim/tb_gated_pose_moving_average.sv @@
// ----------------------------------------------------------------------------
// tb_gated_pose_moving_average: self-checking bench for the gated pose average
// Feeds pose and confidence words through a valid/ready driver, mirrors the
// gate, the sliding window and the running sums in a local model, and checks
// every averaged result word field by field. Register writes go through the
// APB-style port only while the block is idle.
// ----------------------------------------------------------------------------
module tb_gated_pose_moving_average;

   localparam int SETTLE_CYCLES = 300;           // lets an accepted pose finish its divisions
   localparam int RUN_LIMIT     = 20_000_000;    // simulation time before the hard stop

   typedef struct packed {
      logic                                                 func;
      logic [gpma_pkg::CHANNELS-1:0][gpma_pkg::FIELD_W-1:0] chan; // x, y, z, qw, qx, qy, qz
      logic [gpma_pkg::CONF_W-1:0]                          level;
      logic                                                 detected;
   } pose_word_type;

   typedef struct packed {
      logic [gpma_pkg::CHANNELS-1:0][gpma_pkg::FIELD_W-1:0] avg;
      logic [gpma_pkg::USED_W-1:0]                          used;
   } avg_word_type;

   logic clock;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_ready;
   pose_word_type cur_word  = '0;

   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [gpma_pkg::FIELD_W-1:0] rsp_avg_x, rsp_avg_y, rsp_avg_z;
   logic signed [gpma_pkg::FIELD_W-1:0] rsp_avg_qw, rsp_avg_qx, rsp_avg_qy, rsp_avg_qz;
   logic [gpma_pkg::USED_W-1:0]         rsp_samples_used;

   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [gpma_pkg::PADDR_BITS-1:0] csr_paddr   = '0;
   logic [gpma_pkg::PDATA_BITS-1:0] csr_pwdata  = '0;
   logic [gpma_pkg::PDATA_BITS-1:0] csr_prdata;
   logic                            csr_pready;

   // words waiting for the driver, and averages waiting for the monitor
   pose_word_type send_queue[$];
   avg_word_type  avg_queue[$];

   // drop all idling on both sides while set
   logic steady = 1'b0;
   int   mismatches = 0;

   // local copy of the block's state and registers
   logic [gpma_pkg::WLEN_W-1:0]         win_len   = gpma_pkg::WLEN_RESET;
   logic [gpma_pkg::CONF_W-1:0]         conf_min  = gpma_pkg::CONF_MIN_RESET;
   logic                                gate_open = 1'b0;
   logic signed [gpma_pkg::FIELD_W-1:0] pose_window [gpma_pkg::CHANNELS][gpma_pkg::WINDOW_MAX];
   longint                              pose_sums [gpma_pkg::CHANNELS];
   int unsigned                         fill_count  = 0;
   int unsigned                         oldest_slot = 0;

   gated_pose_moving_average dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (cur_word.func),
      .req_pos_x            (cur_word.chan[0]),
      .req_pos_y            (cur_word.chan[1]),
      .req_pos_z            (cur_word.chan[2]),
      .req_quat_w           (cur_word.chan[3]),
      .req_quat_x           (cur_word.chan[4]),
      .req_quat_y           (cur_word.chan[5]),
      .req_quat_z           (cur_word.chan[6]),
      .req_confidence_level (cur_word.level),
      .req_detected         (cur_word.detected),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_avg_x            (rsp_avg_x),
      .rsp_avg_y            (rsp_avg_y),
      .rsp_avg_z            (rsp_avg_z),
      .rsp_avg_qw           (rsp_avg_qw),
      .rsp_avg_qx           (rsp_avg_qx),
      .rsp_avg_qy           (rsp_avg_qy),
      .rsp_avg_qz           (rsp_avg_qz),
      .rsp_samples_used     (rsp_samples_used),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Window model
   // ---------------------------------------------------------------------

   // empty the window: count, oldest slot and sums back to zero
   function automatic void clear_window();
      for (int c = 0; c < gpma_pkg::CHANNELS; c++) pose_sums[c] = 0;
      fill_count  = 0;
      oldest_slot = 0;
   endfunction

   // advance the window by one accepted word; queue an average for open poses
   function automatic void advance_window(input pose_word_type w);
      int unsigned  len, slot;
      avg_word_type r;
      if (w.func == gpma_pkg::FUNC_CONFIDENCE) begin
         gate_open = (w.level > conf_min) && w.detected;
         if (!gate_open) clear_window();
      end else if (gate_open) begin
         // length zero acts as one, anything past the store saturates
         len = (win_len == '0) ? 1 :
               ((int'(win_len) > gpma_pkg::WINDOW_MAX) ? gpma_pkg::WINDOW_MAX : int'(win_len));
         if (fill_count >= len) begin
            // full: drop the oldest sample and reuse its slot
            slot = oldest_slot % len;
            for (int c = 0; c < gpma_pkg::CHANNELS; c++)
               pose_sums[c] -= pose_window[c][slot];
            oldest_slot = (slot + 1) % len;
            fill_count  = len;
         end else begin
            slot = (oldest_slot + fill_count) % len;
            fill_count++;
         end
         for (int c = 0; c < gpma_pkg::CHANNELS; c++) begin
            pose_window[c][slot] = $signed(w.chan[c]);
            pose_sums[c] += longint'($signed(w.chan[c]));
         end
         // signed division truncates toward zero, as the block must
         for (int c = 0; c < gpma_pkg::CHANNELS; c++)
            r.avg[c] = gpma_pkg::FIELD_W'(pose_sums[c] / longint'(fill_count));
         r.used = gpma_pkg::USED_W'(fill_count);
         avg_queue = {avg_queue, r};
      end
   endfunction

   // ---------------------------------------------------------------------
   // Input driver: present queued words, idle now and then between them
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         // a word went through at this edge: fold it into the model
         if (req_valid) advance_window(cur_word);
         if (send_queue.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
            cur_word  <= send_queue[0];
            send_queue.delete(0);
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random back-pressure, then compare against the oldest average
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin : check_results
      avg_word_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.avg  = {rsp_avg_qz, rsp_avg_qy, rsp_avg_qx, rsp_avg_qw,
                     rsp_avg_z, rsp_avg_y, rsp_avg_x};
         got.used = rsp_samples_used;
         if (avg_queue.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result word: avg_x %h used %0d", got.avg[0], got.used);
            mismatches++;
         end else begin
            want = avg_queue[0];
            avg_queue.delete(0);
            for (int c = 0; c < gpma_pkg::CHANNELS; c++) begin
               if (got.avg[c] !== want.avg[c]) begin
                  if (mismatches < 10)
                     $display("average channel %0d: expected %h got %h",
                              c, want.avg[c], got.avg[c]);
                  mismatches++;
               end
            end
            if (got.used !== want.used) begin
               if (mismatches < 10)
                  $display("samples_used: expected %0d got %0d", want.used, got.used);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic pose_word_type pose_of(input logic [31:0] x, y, z, qw, qx, qy, qz);
      pose_word_type w;
      w          = '0;
      w.func     = gpma_pkg::FUNC_POSE;
      w.chan     = {qz, qy, qx, qw, z, y, x};
      w.level    = gpma_pkg::CONF_W'($urandom);     // ignored on poses, toggle it anyway
      w.detected = 1'($urandom);
      return w;
   endfunction

   // same value on all seven channels
   function automatic pose_word_type pose_same(input logic [31:0] v);
      return pose_of(v, v, v, v, v, v, v);
   endfunction

   function automatic pose_word_type conf_of(input logic [gpma_pkg::CONF_W-1:0] level,
                                             input logic det);
      pose_word_type w;
      w          = '0;
      w.func     = gpma_pkg::FUNC_CONFIDENCE;
      for (int c = 0; c < gpma_pkg::CHANNELS; c++) w.chan[c] = $urandom;
      w.level    = level;
      w.detected = det;
      return w;
   endfunction

   // append one word behind the ones already waiting for the driver
   function automatic void enqueue(input pose_word_type w);
      send_queue = {send_queue, w};
   endfunction

   // mix of extremes, small Q15.16 values and raw random words
   function automatic logic [31:0] rand_field();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return 32'($signed($urandom_range(2097152)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   // levels clustered around the threshold, leaning toward opening the gate
   function automatic logic [gpma_pkg::CONF_W-1:0] rand_level();
      case ($urandom_range(6))
         0:       return conf_min + 1'b1;
         1:       return conf_min;
         2:       return conf_min - 1'b1;
         3:       return 16'hFFFF;
         4:       return 16'h0000;
         default: return (conf_min == 16'hFFFF) ? 16'hFFFF :
                          gpma_pkg::CONF_W'($urandom_range(65535, int'(conf_min) + 1));
      endcase
   endfunction

   // queue n random words, mostly poses with a confidence update now and then
   task automatic queue_random(input int n);
      pose_word_type w;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) begin
            w = conf_of(rand_level(), $urandom_range(99) < 85);
         end else begin
            w = pose_of(rand_field(), rand_field(), rand_field(), rand_field(),
                        rand_field(), rand_field(), rand_field());
         end
         enqueue(w);
      end
   endtask

   // hold until every word is through and every average is back, then let
   // the divider finish anything still in flight
   task automatic settle();
      while (send_queue.size() != 0 || req_valid || avg_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one APB write: setup cycle, then access until pready
   task automatic write_reg(input gpma_pkg::reg_index_type idx,
                            input logic [gpma_pkg::PDATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= gpma_pkg::PADDR_BITS'(4 * idx);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // mirror the register write in the model
      if (idx == gpma_pkg::REG_WINDOW_LENGTH) begin
         win_len = data[gpma_pkg::WLEN_W-1:0];
         clear_window();
      end else begin
         conf_min = data[gpma_pkg::CONF_W-1:0];
      end
   endtask

   task automatic run_phase(input logic [gpma_pkg::PDATA_BITS-1:0] wlen,
                            input logic [gpma_pkg::PDATA_BITS-1:0] cmin,
                            input int n);
      write_reg(gpma_pkg::REG_WINDOW_LENGTH, wlen);
      write_reg(gpma_pkg::REG_CONF_THRESHOLD, cmin);
      queue_random(n);
      settle();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset settings: window 5, threshold one half
      // pose with the gate still closed after reset: drop it
      enqueue(pose_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678));
      // level equal to the threshold must not open the gate
      enqueue(conf_of(16'd32768, 1'b1));
      enqueue(pose_of(32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7));
      // full confidence without detection keeps it closed
      enqueue(conf_of(16'hFFFF, 1'b0));
      // one step above the threshold with detection opens it
      enqueue(conf_of(16'd32769, 1'b1));
      enqueue(pose_same(32'h7FFF_FFFF));
      enqueue(pose_same(32'h8000_0000));
      enqueue(pose_same(32'h0000_0000));
      enqueue(pose_same(32'hFFFF_FFFF));
      enqueue(pose_of(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                      32'h0001_0000, 32'h0, 32'h0, 32'h0));
      // window now full: wrap and drop the oldest
      enqueue(pose_same(32'h7FFF_FFFF));
      enqueue(pose_same(32'h8000_0000));
      enqueue(pose_of(rand_field(), rand_field(), rand_field(), rand_field(),
                      rand_field(), rand_field(), rand_field()));
      // zero level closes the gate and clears the window
      enqueue(conf_of(16'h0000, 1'b1));
      enqueue(pose_same(32'h5555_AAAA));
      enqueue(conf_of(16'hFFFF, 1'b1));
      enqueue(pose_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                      32'h8000_0001, 32'h7FFF_FFFE, 32'h0));
      enqueue(pose_same(32'hFFFF_FFFF));
      // open gate stays open on a second passing update: keep the window
      enqueue(conf_of(16'd40000, 1'b1));
      enqueue(pose_same(32'h0000_0003));
      settle();

      // random phases across the register range, extremes included
      run_phase(32'd1, 32'd0, 150);
      run_phase(32'd16, 32'hFFFF, 20);      // gate can never reopen
      run_phase(32'd0, 32'd32768, 120);     // zero length acts as one
      run_phase(32'd31, $urandom, 200);     // saturates at the store depth

      // upper data bits set; sender pauses mid-phase until all averages are back
      write_reg(gpma_pkg::REG_WINDOW_LENGTH, {27'($urandom), 5'd5});
      write_reg(gpma_pkg::REG_CONF_THRESHOLD, 32'd100);
      queue_random(100);
      settle();
      queue_random(100);
      settle();

      run_phase(32'($urandom_range(16, 1)), 32'($urandom_range(65535)), 120);
      // long stretch with no idling on either side
      steady = 1'b1;
      run_phase(32'($urandom_range(16, 1)), 32'($urandom_range(40000)), 120);
      steady = 1'b0;
      run_phase(32'($urandom_range(16, 1)), 32'($urandom_range(65535)), 120);

      if (mismatches == 0 && avg_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/gpma_pkg.sv
rtl/gpma_csr.sv
rtl/gpma_div.sv
rtl/gpma_dp.sv
rtl/gpma_ctrl.sv
rtl/gated_pose_moving_average.sv
sim/tb_gated_pose_moving_average.sv
